### sv/frac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fraction reducer.
// Used by frac_divider, fraction_reducer and frac_checker; depends on nothing.
package frac_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int MAG_WIDTH  = DATA_WIDTH - 1;
	localparam int CNT_WIDTH  = $clog2(MAG_WIDTH);

	localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {MAG_WIDTH{1'b0}}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_MOST_NEG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_GCD_TEST,
		S_GCD_WAIT,
		S_NUM_WAIT,
		S_DEN_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] numerator_in;
		logic signed [DATA_WIDTH-1:0] denominator_in;
	} in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] numerator_out;
		logic        [MAG_WIDTH-1:0]  denominator_out;
		status_t                      status;
	} out_t;

	typedef struct packed {
		logic                 start;
		logic [MAG_WIDTH-1:0] dividend;
		logic [MAG_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [MAG_WIDTH-1:0] quotient;
		logic [MAG_WIDTH-1:0] remainder;
	} div_rsp_t;

endpackage

### sv/frac_divider.sv
`timescale 1ns / 1ps
// Restoring shift-subtract divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on frac_pkg for widths and request/response structs.
module frac_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  frac_pkg::div_req_t req,
	output frac_pkg::div_rsp_t rsp
);

	logic                           run_q;
	logic                           done_q;
	logic [frac_pkg::CNT_WIDTH-1:0] cnt_q;
	logic [frac_pkg::MAG_WIDTH-1:0] rem_q;
	logic [frac_pkg::MAG_WIDTH-1:0] dvd_q;
	logic [frac_pkg::MAG_WIDTH-1:0] dsr_q;

	logic [frac_pkg::MAG_WIDTH:0]   trial;
	logic [frac_pkg::MAG_WIDTH:0]   diff;
	logic                           fits;

	assign trial = {rem_q, dvd_q[frac_pkg::MAG_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = !diff[frac_pkg::MAG_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= frac_pkg::CNT_WIDTH'(frac_pkg::MAG_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[frac_pkg::MAG_WIDTH-1:0] : trial[frac_pkg::MAG_WIDTH-1:0];
			dvd_q <= {dvd_q[frac_pkg::MAG_WIDTH-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

### sv/fraction_reducer.sv
`timescale 1ns / 1ps
// Fraction reducer top level: operand latch, sequencer and result register.
// Depends on frac_pkg and frac_divider.
//
// Reduces a signed fraction to lowest terms; the sign goes on the numerator and
// the denominator is positive. Pulse start while busy is low to transfer one
// operand pair; busy stays high until the result is shown. The result appears
// on result for exactly one cycle with done high and must be taken then: there
// is no way to hold it off. A zero denominator reports status ST_ZERO_DEN, a
// most negative operand (with a nonzero numerator) ST_MOST_NEG, both with zero
// outputs; a zero numerator gives 0/1. Those cases go from S_CHECK straight to
// S_DONE. Otherwise every Euclid step and the two final divisions each run on
// the one shared shift-subtract divider at one bit per cycle: the remainder
// steps run in S_GCD_TEST and S_GCD_WAIT until the remainder is zero, then the
// numerator quotient is taken in S_NUM_WAIT and the denominator in S_DEN_WAIT.
module fraction_reducer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  frac_pkg::in_t   operands,
	output logic            busy,
	output logic            done,
	output frac_pkg::out_t  result
);

	frac_pkg::state_t               state_q;
	frac_pkg::state_t               state_d;
	frac_pkg::div_req_t             div_req;
	frac_pkg::div_rsp_t             div_rsp;

	logic [frac_pkg::DATA_WIDTH-1:0] x_q;
	logic [frac_pkg::DATA_WIDTH-1:0] y_q;
	logic [frac_pkg::MAG_WIDTH-1:0]  mx_q;
	logic [frac_pkg::MAG_WIDTH-1:0]  my_q;
	logic [frac_pkg::MAG_WIDTH-1:0]  p_q;
	logic [frac_pkg::MAG_WIDTH-1:0]  q_q;
	logic [frac_pkg::MAG_WIDTH-1:0]  qn_q;
	logic                            neg_q;
	frac_pkg::out_t                  result_q;

	logic [frac_pkg::DATA_WIDTH-1:0] x_abs;
	logic [frac_pkg::DATA_WIDTH-1:0] y_abs;
	logic [frac_pkg::DATA_WIDTH-1:0] num_ext;
	logic [frac_pkg::DATA_WIDTH-1:0] num_signed;
	logic                            special;

	assign x_abs      = x_q[frac_pkg::DATA_WIDTH-1] ? ('0 - x_q) : x_q;
	assign y_abs      = y_q[frac_pkg::DATA_WIDTH-1] ? ('0 - y_q) : y_q;
	assign special    = (y_q == '0) || (x_q == '0)
		|| (x_q == frac_pkg::MOST_NEG) || (y_q == frac_pkg::MOST_NEG);
	assign num_ext    = {1'b0, qn_q};
	assign num_signed = neg_q ? ('0 - num_ext) : num_ext;

	frac_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frac_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			frac_pkg::S_IDLE: begin
				if (start) state_d = frac_pkg::S_CHECK;
			end
			frac_pkg::S_CHECK: begin
				state_d = special ? frac_pkg::S_DONE : frac_pkg::S_GCD_TEST;
			end
			frac_pkg::S_GCD_TEST: begin
				state_d = (p_q == '0) ? frac_pkg::S_NUM_WAIT : frac_pkg::S_GCD_WAIT;
			end
			frac_pkg::S_GCD_WAIT: begin
				if (div_rsp.done) state_d = frac_pkg::S_GCD_TEST;
			end
			frac_pkg::S_NUM_WAIT: begin
				if (div_rsp.done) state_d = frac_pkg::S_DEN_WAIT;
			end
			frac_pkg::S_DEN_WAIT: begin
				if (div_rsp.done) state_d = frac_pkg::S_DONE;
			end
			frac_pkg::S_DONE: begin
				state_d = frac_pkg::S_IDLE;
			end
			default: begin
				state_d = frac_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy             = (state_q != frac_pkg::S_IDLE);
		done             = (state_q == frac_pkg::S_DONE);
		div_req.start    = 1'b0;
		div_req.dividend = q_q;
		div_req.divisor  = p_q;
		case (state_q)
			frac_pkg::S_GCD_TEST: begin
				div_req.start = 1'b1;
				if (p_q == '0) begin
					div_req.dividend = mx_q;
					div_req.divisor  = q_q;
				end
			end
			frac_pkg::S_NUM_WAIT: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = my_q;
				div_req.divisor  = q_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			frac_pkg::S_IDLE: begin
				if (start) begin
					x_q <= operands.numerator_in;
					y_q <= operands.denominator_in;
				end
			end
			frac_pkg::S_CHECK: begin
				mx_q  <= x_abs[frac_pkg::MAG_WIDTH-1:0];
				my_q  <= y_abs[frac_pkg::MAG_WIDTH-1:0];
				p_q   <= x_abs[frac_pkg::MAG_WIDTH-1:0];
				q_q   <= y_abs[frac_pkg::MAG_WIDTH-1:0];
				neg_q <= x_q[frac_pkg::DATA_WIDTH-1] ^ y_q[frac_pkg::DATA_WIDTH-1];
				if (y_q == '0) begin
					result_q.numerator_out   <= '0;
					result_q.denominator_out <= '0;
					result_q.status          <= frac_pkg::ST_ZERO_DEN;
				end else if (x_q == '0) begin
					result_q.numerator_out   <= '0;
					result_q.denominator_out <= frac_pkg::MAG_WIDTH'(1);
					result_q.status          <= frac_pkg::ST_OK;
				end else begin
					result_q.numerator_out   <= '0;
					result_q.denominator_out <= '0;
					result_q.status          <= frac_pkg::ST_MOST_NEG;
				end
			end
			frac_pkg::S_GCD_WAIT: begin
				if (div_rsp.done) begin
					q_q <= p_q;
					p_q <= div_rsp.remainder;
				end
			end
			frac_pkg::S_NUM_WAIT: begin
				if (div_rsp.done) qn_q <= div_rsp.quotient;
			end
			frac_pkg::S_DEN_WAIT: begin
				if (div_rsp.done) begin
					result_q.numerator_out   <= $signed(num_signed);
					result_q.denominator_out <= div_rsp.quotient;
					result_q.status          <= frac_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign result = result_q;

endmodule

### sv/frac_checker.sv
`timescale 1ns / 1ps
// Port-level checker for fraction_reducer, attached by the bind below.
// Depends on frac_pkg and the fraction_reducer ports.
module frac_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input frac_pkg::out_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted but busy not raised");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == frac_pkg::ST_OK |-> result.denominator_out != '0)
		else $error("zero denominator with ok status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == frac_pkg::ST_ZERO_DEN
			|| result.status == frac_pkg::ST_MOST_NEG)
		|-> result.numerator_out == '0 && result.denominator_out == '0)
		else $error("error status with nonzero outputs");

endmodule

bind fraction_reducer frac_checker u_frac_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
